FILE: src/png_scanline_unfilter_core_assert.svh
// Assertion macros for the scanline unfilter port checker
`ifndef PNG_SCANLINE_UNFILTER_CORE_ASSERT_SVH
`define PNG_SCANLINE_UNFILTER_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, quiet while rst_ni is low
`define PSU_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, quiet while rst_ni is low
`define PSU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/psu_pkg.sv
// Types, constants and the Paeth predictor shared by the scanline unfilter
`default_nettype none
package psu_pkg;

  // Filter type codes of a scanline; anything above Paeth folds into FILT_BAD
  typedef enum logic [2:0] {
    FILT_NONE  = 3'd0,
    FILT_SUB   = 3'd1,
    FILT_UP    = 3'd2,
    FILT_AVG   = 3'd3,
    FILT_PAETH = 3'd4,
    FILT_BAD   = 3'd5
  } filt_e;

  localparam logic [7:0] FILT_TYPE_MAX = 8'd4;

  // Pixel history: up to eight bytes per pixel
  localparam int unsigned PIX_BYTES = 8;
  localparam int unsigned PIX_IDX_W = 3;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 14;
  localparam int unsigned BPP_W      = 4;
  localparam int unsigned ROWB_W     = 14;

  localparam logic [CFG_IDX_W-1:0] REG_BPP       = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_BYTES = 1'b1;

  // Operands of one byte reconstruction
  typedef struct packed {
    filt_e      filt;
    logic [7:0] left;
    logic [7:0] up;
    logic [7:0] upleft;
  } pred_in_t;

  // Paeth predictor: nearest of left, up, upper-left to left + up - upper-left
  function automatic logic [7:0] paeth(input logic [7:0] a, input logic [7:0] b,
                                       input logic [7:0] c);
    logic signed [9:0] da;
    logic signed [9:0] db;
    logic signed [9:0] dc;
    logic [9:0]        pa;
    logic [9:0]        pb;
    logic [9:0]        pc;
    logic [7:0]        res;
    da = $signed({2'b00, b}) - $signed({2'b00, c});
    db = $signed({2'b00, a}) - $signed({2'b00, c});
    dc = $signed({2'b00, a}) + $signed({2'b00, b}) - $signed({1'b0, c, 1'b0});
    pa = da[9] ? 10'(-da) : 10'(da);
    pb = db[9] ? 10'(-db) : 10'(db);
    pc = dc[9] ? 10'(-dc) : 10'(dc);
    if (pa <= pb && pa <= pc) begin
      res = a;
    end else if (pb <= pc) begin
      res = b;
    end else begin
      res = c;
    end
    return res;
  endfunction

endpackage
`default_nettype wire

FILE: src/png_scanline_unfilter_core.sv
// Top level of the PNG scanline unfilter: stream control, pixel history, result register
//
//   channel | signals                                  | direction
//   --------+------------------------------------------+----------
//   in      | in_valid_i in_ready_o data_byte_i         | sink
//           | image_start_i                            |
//   out     | out_valid_o out_ready_i pixel_byte_o      | source
//           | row_end_o bad_filter_o                   |
//   cfg     | cfg_valid_i cfg_ready_o cfg_index_i      | sink
//           | cfg_data_i                               |
//
// One byte a cycle while the output is not stalled; a data byte passes the input
// register, then reconstruction into the result register, before it is offered at
// the output.
// The above byte is prefetched from the row store at the next column address.
// Filter-type bytes are consumed without an output beat.
// A stalled output holds the result register; one further beat waits in the
// input register. Reset needs no clearing pass; config writes are always taken.
`default_nettype none
module png_scanline_unfilter_core import psu_pkg::*; #(
  parameter int unsigned MAX_ROW_BYTES = 8192
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // input stream
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [7:0]            data_byte_i,
  input  logic                  image_start_i,
  // output stream
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [7:0]            pixel_byte_o,
  output logic                  row_end_o,
  output logic                  bad_filter_o,
  // configuration
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned COL_W = $clog2(MAX_ROW_BYTES);
  localparam int unsigned CMP_W = (COL_W + 1 > ROWB_W) ? COL_W + 1 : ROWB_W;

  // Configuration registers
  logic [BPP_W-1:0]  bpp_q;
  logic [ROWB_W-1:0] row_bytes_q;

  // Input register
  logic       s1_valid_q;
  logic [7:0] s1_byte_q;
  logic       s1_start_q;

  // Row state
  logic             expect_type_q, expect_type_d;
  logic             first_row_q, first_row_d;
  logic [COL_W-1:0] column_q, column_d;
  filt_e            row_filter_q, row_filter_d;
  logic [7:0]       left_hist_q [PIX_BYTES];
  logic [7:0]       upleft_hist_q [PIX_BYTES];

  // Result register
  logic       out_valid_q;
  logic [7:0] pixel_q;
  logic       row_end_q;
  logic       bad_q;

  logic                 is_type;
  logic                 out_free;
  logic                 s1_fire;
  logic                 data_fire;
  logic [PIX_IDX_W-1:0] bpp_idx;
  logic [CMP_W-1:0]     rb_ext;
  logic [CMP_W-1:0]     rb_eff;
  logic                 last;
  logic [7:0]           mem_rd;
  logic [7:0]           up;
  pred_in_t             ops;
  logic [7:0]           raw_byte;
  logic                 bad;

  assign cfg_ready_o = 1'b1;

  // Take configuration beats
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bpp_q       <= BPP_W'(1);
      row_bytes_q <= ROWB_W'(1);
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_BPP:       bpp_q       <= cfg_data_i[BPP_W-1:0];
        REG_ROW_BYTES: row_bytes_q <= cfg_data_i[ROWB_W-1:0];
        default: ;
      endcase
    end
  end

  // Handshake between input register and result register
  assign is_type    = expect_type_q | s1_start_q;
  assign out_free   = ~out_valid_q | out_ready_i;
  assign s1_fire    = s1_valid_q & (is_type | out_free);
  assign data_fire  = s1_fire & ~is_type;
  assign in_ready_o = ~s1_valid_q | s1_fire;

  // Capture input beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_byte_q  <= data_byte_i;
      s1_start_q <= image_start_i;
    end
  end

  // Clamp bytes per pixel and row length
  always_comb begin
    if (bpp_q == '0) begin
      bpp_idx = '0;
    end else if (bpp_q > BPP_W'(PIX_BYTES)) begin
      bpp_idx = PIX_IDX_W'(PIX_BYTES - 1);
    end else begin
      bpp_idx = PIX_IDX_W'(bpp_q - BPP_W'(1));
    end
  end

  assign rb_ext = CMP_W'(row_bytes_q);

  always_comb begin
    if (rb_ext == '0) begin
      rb_eff = CMP_W'(1);
    end else if (rb_ext > CMP_W'(MAX_ROW_BYTES)) begin
      rb_eff = CMP_W'(MAX_ROW_BYTES);
    end else begin
      rb_eff = rb_ext;
    end
  end

  assign last = (CMP_W'(column_q) + CMP_W'(1)) >= rb_eff;

  // Gather operands
  assign up         = first_row_q ? 8'd0 : mem_rd;
  assign ops.filt   = row_filter_q;
  assign ops.left   = left_hist_q[bpp_idx];
  assign ops.up     = up;
  assign ops.upleft = upleft_hist_q[bpp_idx];

  psu_predict u_predict (
    .ops_i       (ops),
    .filt_byte_i (s1_byte_q),
    .raw_byte_o  (raw_byte),
    .bad_o       (bad)
  );

  // Next row state
  always_comb begin
    expect_type_d = expect_type_q;
    first_row_d   = first_row_q;
    column_d      = column_q;
    row_filter_d  = row_filter_q;
    if (s1_fire) begin
      if (is_type) begin
        expect_type_d = 1'b0;
        column_d      = '0;
        if (s1_start_q) begin
          first_row_d = 1'b1;
        end
        if (s1_byte_q > FILT_TYPE_MAX) begin
          row_filter_d = FILT_BAD;
        end else begin
          row_filter_d = filt_e'(s1_byte_q[2:0]);
        end
      end else if (last) begin
        column_d      = '0;
        expect_type_d = 1'b1;
        first_row_d   = 1'b0;
      end else begin
        column_d = column_q + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expect_type_q <= 1'b1;
      first_row_q   <= 1'b1;
      column_q      <= '0;
      row_filter_q  <= FILT_NONE;
    end else begin
      expect_type_q <= expect_type_d;
      first_row_q   <= first_row_d;
      column_q      <= column_d;
      row_filter_q  <= row_filter_d;
    end
  end

  // Clear histories on a type byte, shift in on a data byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < PIX_BYTES; i++) begin
        left_hist_q[i]   <= 8'd0;
        upleft_hist_q[i] <= 8'd0;
      end
    end else if (s1_fire) begin
      if (is_type) begin
        for (int i = 0; i < PIX_BYTES; i++) begin
          left_hist_q[i]   <= 8'd0;
          upleft_hist_q[i] <= 8'd0;
        end
      end else begin
        for (int i = PIX_BYTES - 1; i > 0; i--) begin
          left_hist_q[i]   <= left_hist_q[i-1];
          upleft_hist_q[i] <= upleft_hist_q[i-1];
        end
        left_hist_q[0]   <= raw_byte;
        upleft_hist_q[0] <= up;
      end
    end
  end

  // Previous row: write this column, prefetch the next one
  psu_row_mem #(
    .DEPTH (MAX_ROW_BYTES),
    .AW    (COL_W)
  ) u_row_mem (
    .clk_i     (clk_i),
    .wr_en_i   (data_fire),
    .wr_addr_i (column_q),
    .wr_data_i (raw_byte),
    .rd_addr_i (column_d),
    .rd_data_o (mem_rd)
  );

  // Result register: load on a data byte, drop when taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (data_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (data_fire) begin
      pixel_q   <= raw_byte;
      row_end_q <= last;
      bad_q     <= bad;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign pixel_byte_o = pixel_q;
  assign row_end_o    = row_end_q;
  assign bad_filter_o = bad_q;

endmodule
`default_nettype wire

FILE: src/psu_row_mem.sv
// Previous-row byte store: one write port, one registered read port
`default_nettype none
module psu_row_mem #(
  parameter int unsigned DEPTH = 8192,
  parameter int unsigned AW    = 13
) (
  input  logic          clk_i,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  logic [7:0]    wr_data_i,
  input  logic [AW-1:0] rd_addr_i,
  output logic [7:0]    rd_data_o
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rd_data_q;

  // Write the reconstructed byte
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // Read every cycle; forward a write to the same address
  always_ff @(posedge clk_i) begin
    if (wr_en_i && (wr_addr_i == rd_addr_i)) begin
      rd_data_q <= wr_data_i;
    end else begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule
`default_nettype wire

FILE: src/psu_predict.sv
// Byte reconstruction for the five filter types
`default_nettype none
module psu_predict import psu_pkg::*; (
  input  pred_in_t   ops_i,
  input  logic [7:0] filt_byte_i,
  output logic [7:0] raw_byte_o,
  output logic       bad_o
);

  logic [8:0] avg_sum;
  logic [7:0] pred;

  assign avg_sum = {1'b0, ops_i.left} + {1'b0, ops_i.up};

  // Select the predictor of the row's filter type
  always_comb begin
    bad_o = 1'b0;
    case (ops_i.filt)
      FILT_NONE:  pred = 8'd0;
      FILT_SUB:   pred = ops_i.left;
      FILT_UP:    pred = ops_i.up;
      FILT_AVG:   pred = avg_sum[8:1];
      FILT_PAETH: pred = paeth(ops_i.left, ops_i.up, ops_i.upleft);
      default: begin
        pred  = 8'd0;
        bad_o = 1'b1;
      end
    endcase
  end

  // Add modulo 256
  assign raw_byte_o = filt_byte_i + pred;

endmodule
`default_nettype wire

FILE: src/psu_port_chk.sv
// Port-level checks of the scanline unfilter, bound to the top level
`default_nettype none
`include "png_scanline_unfilter_core_assert.svh"
module psu_port_chk import psu_pkg::*; (
  input wire logic                  clk_i,
  input wire logic                  rst_ni,
  input wire logic                  in_valid_i,
  input wire logic                  in_ready_o,
  input wire logic [7:0]            data_byte_i,
  input wire logic                  image_start_i,
  input wire logic                  out_valid_o,
  input wire logic                  out_ready_i,
  input wire logic [7:0]            pixel_byte_o,
  input wire logic                  row_end_o,
  input wire logic                  bad_filter_o,
  input wire logic                  cfg_valid_i,
  input wire logic                  cfg_ready_o,
  input wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  // Hold an unaccepted output beat
  `PSU_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o, "output beat dropped while stalled")

  // Keep a stalled output payload
  `PSU_ASSERT_NEXT(a_out_stable, out_valid_o && !out_ready_i, $stable(pixel_byte_o) && $stable(row_end_o) && $stable(bad_filter_o), "stalled output payload changed")

  // Back-pressure only while a result waits
  `PSU_ASSERT_NOW(a_stall_cause, !in_ready_o, out_valid_o && !$past(cfg_valid_i && !cfg_ready_o), "input stalled with empty output")

  // A fresh result stems from an earlier input beat through the input register
  `PSU_ASSERT_NOW(a_out_origin, $rose(out_valid_o), $past(in_valid_i && in_ready_o, 2), "output beat without input beat")

endmodule

bind png_scanline_unfilter_core psu_port_chk u_port_chk (.*);
`default_nettype wire
